@@ design/assert_macros.svh @@
// Assertion helpers for the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When trig holds, cond must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

@@ design/ile_pkg.sv @@
package ile_pkg;

	localparam int unsigned CAPACITY_DEF = 64;

	typedef enum logic [3:0] {
		CMD_ADD_FIRST     = 4'd0,
		CMD_ADD_LAST      = 4'd1,
		CMD_INSERT_BEFORE = 4'd2,
		CMD_INSERT_AFTER  = 4'd3,
		CMD_REMOVE_FIRST  = 4'd4,
		CMD_REMOVE_LAST   = 4'd5,
		CMD_REMOVE_AT     = 4'd6,
		CMD_READ_AT       = 4'd7,
		CMD_FIND_VALUE    = 4'd8
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_WR,
		S_PUT,
		S_GET_RD,
		S_GET_USE,
		S_SH_RD,
		S_SH_WR,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_OUT
	} state_t;

endpackage

@@ design/indexed_list_engine.sv @@
`include "assert_macros.svh"

// Ordered list of signed 32-bit words, up to CAPACITY entries, held in one
// simple dual-port synchronous RAM (one read, one write per cycle, read data
// registered). Each command yields one result word. Rejected commands (full
// insert, empty or out-of-range remove or read, unused codes, find on an empty
// list) go straight to the output state. read_at reads entry k; insert at k
// shifts entries k and up by one, then writes the value; remove at k reads
// entry k, then shifts the entries above it down; find_value compares entries
// in turn until a match or the list end. Shifting and scanning move one entry
// per read state and write or compare state. A new command is taken once the
// engine is idle, while the previous result may still wait on the output; a
// result that is not taken holds the engine in its output state. No clearing
// pass after reset: data past the count is never used.
module indexed_list_engine
	import ile_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         cmd,
	input  logic [7:0]         position,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [31:0] read_value,
	output logic [5:0]         found_index,
	output logic [6:0]         item_count,
	output logic               is_empty
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned PW = (CW > 8) ? CW : 8;

	logic [31:0] mem [CAPACITY];
	logic [31:0] rdata_q;

	state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] ptr_q;
	logic [CW-1:0] at_q;
	logic [31:0]   val_q;
	status_t       res_status_q;
	logic [31:0]   res_val_q;
	logic [CW-1:0] res_idx_q;

	logic          out_valid_q;
	status_t       status_q;
	logic [31:0]   read_value_q;
	logic [5:0]    found_index_q;
	logic [6:0]    item_count_q;
	logic          is_empty_q;

	logic          accept;
	logic [PW-1:0] pos_x, cnt_x;
	logic          pos_in;
	logic          full;
	logic [CW-1:0] at_ins;

	logic          re, we;
	logic [AW-1:0] ra, wa;
	logic [31:0]   wd;
	logic [CW-1:0] ptr_dn, ptr_up;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign pos_x    = PW'(position);
	assign cnt_x    = PW'(count_q);
	assign pos_in   = pos_x < cnt_x;
	assign full     = (count_q == CW'(CAPACITY));
	assign ptr_dn   = ptr_q - 1'b1;
	assign ptr_up   = ptr_q + 1'b1;

	always_comb begin
		case (cmd_t'(cmd))
			CMD_ADD_FIRST:     at_ins = '0;
			CMD_INSERT_BEFORE: at_ins = pos_in ? CW'(position) : count_q;
			CMD_INSERT_AFTER:  at_ins = pos_in ? CW'(pos_x + 1'b1) : count_q;
			default:           at_ins = count_q;
		endcase
	end

	// RAM port control
	always_comb begin
		re = 1'b0;
		ra = '0;
		we = 1'b0;
		wa = '0;
		wd = rdata_q;
		unique case (state_q)
			S_INS_RD: begin
				re = 1'b1;
				ra = ptr_dn[AW-1:0];
			end
			S_INS_WR, S_SH_WR: begin
				we = 1'b1;
				wa = ptr_q[AW-1:0];
			end
			S_PUT: begin
				we = 1'b1;
				wa = at_q[AW-1:0];
				wd = val_q;
			end
			S_GET_RD: begin
				re = 1'b1;
				ra = at_q[AW-1:0];
			end
			S_SH_RD: begin
				re = 1'b1;
				ra = ptr_up[AW-1:0];
			end
			S_SCAN_RD: begin
				re = 1'b1;
				ra = ptr_q[AW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		if (re)
			rdata_q <= mem[ra];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_OUT;
					unique case (cmd_t'(cmd))
						CMD_ADD_FIRST, CMD_ADD_LAST, CMD_INSERT_BEFORE,
						CMD_INSERT_AFTER: begin
							if (!full)
								state_d = (at_ins == count_q) ? S_PUT : S_INS_RD;
						end
						CMD_REMOVE_FIRST, CMD_REMOVE_LAST:
							if (count_q != '0)
								state_d = S_GET_RD;
						CMD_REMOVE_AT, CMD_READ_AT:
							if (pos_in)
								state_d = S_GET_RD;
						CMD_FIND_VALUE:
							if (count_q != '0)
								state_d = S_SCAN_RD;
						default: ;
					endcase
				end
			end
			S_INS_RD:   state_d = S_INS_WR;
			S_INS_WR:   state_d = (ptr_dn == at_q) ? S_PUT : S_INS_RD;
			S_PUT:      state_d = S_OUT;
			S_GET_RD:   state_d = S_GET_USE;
			S_GET_USE:  state_d = S_SH_RD;
			S_SH_RD:    state_d = S_SH_WR;
			S_SH_WR:    state_d = S_SH_RD;
			S_SCAN_RD:  state_d = S_SCAN_CMP;
			S_SCAN_CMP: state_d = S_SCAN_RD;
			S_OUT:      if (!out_valid_q || out_ready) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
		// early exits after the fetch and out of the shift and scan loops
		if (state_q == S_GET_USE && (res_status_q != ST_OK || !val_q[0]))
			state_d = S_OUT;
		// count already dropped: shift while the source index is below the old count
		if (state_q == S_SH_RD && ptr_up > count_q)
			state_d = S_OUT;
		if (state_q == S_SCAN_CMP && (rdata_q == val_q || ptr_up >= count_q))
			state_d = S_OUT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// count and command bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			res_status_q <= ST_MISS;
		end else begin
			unique case (state_q)
				S_IDLE: if (accept) begin
					res_status_q <= ST_MISS;
					if (cmd_t'(cmd) == CMD_ADD_FIRST || cmd_t'(cmd) == CMD_ADD_LAST ||
					    cmd_t'(cmd) == CMD_INSERT_BEFORE ||
					    cmd_t'(cmd) == CMD_INSERT_AFTER)
						res_status_q <= full ? ST_FULL : ST_OK;
					else if (state_d == S_GET_RD)
						res_status_q <= ST_OK;
				end
				S_PUT: count_q <= count_q + 1'b1;
				S_GET_USE: if (res_status_q == ST_OK && val_q[0])
					count_q <= count_q - 1'b1;
				S_SCAN_CMP: if (rdata_q == val_q)
					res_status_q <= ST_OK;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (accept) begin
				res_val_q <= '0;
				res_idx_q <= '0;
				unique case (cmd_t'(cmd))
					CMD_ADD_FIRST, CMD_ADD_LAST, CMD_INSERT_BEFORE,
					CMD_INSERT_AFTER: begin
						at_q  <= at_ins;
						ptr_q <= count_q;
						val_q <= value;
					end
					CMD_REMOVE_FIRST: begin
						at_q  <= '0;
						val_q <= 32'd1;
					end
					CMD_REMOVE_LAST: begin
						at_q  <= count_q - 1'b1;
						val_q <= 32'd1;
					end
					CMD_REMOVE_AT: begin
						at_q  <= CW'(position);
						val_q <= 32'd1;
					end
					CMD_READ_AT: begin
						at_q  <= CW'(position);
						val_q <= 32'd0;
					end
					default: begin
						ptr_q <= '0;
						val_q <= value;
					end
				endcase
				// mark a remove_first or remove_last on an empty list as failed
				if ((cmd_t'(cmd) == CMD_REMOVE_FIRST || cmd_t'(cmd) == CMD_REMOVE_LAST)
				    && count_q == '0)
					val_q <= 32'd0;
			end
			S_INS_WR: ptr_q <= ptr_dn;
			S_GET_USE: begin
				res_val_q <= rdata_q;
				ptr_q     <= at_q;
			end
			S_SH_WR: ptr_q <= ptr_up;
			S_SCAN_CMP: begin
				if (rdata_q == val_q)
					res_idx_q <= ptr_q;
				ptr_q <= ptr_up;
			end
			default: ;
		endcase
	end

	// For reads val_q is zero, so no shift happens and the count holds.
	// Shifting after a remove only runs when val_q[0] is set.
	// (read_at leaves S_GET_USE straight to S_OUT via the early exit above.)

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (state_q == S_OUT && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
			status_q      <= res_status_q;
			read_value_q  <= (res_status_q == ST_OK) ? res_val_q : '0;
			found_index_q <= (res_status_q == ST_OK) ? 6'(res_idx_q) : '0;
			item_count_q  <= 7'(count_q);
			is_empty_q    <= (count_q == '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign read_value  = read_value_q;
	assign found_index = found_index_q;
	assign item_count  = item_count_q;
	assign is_empty    = is_empty_q;

	`ASSERT_ALWAYS(a_count_cap, clk, arst_n, count_q <= CW'(CAPACITY), "count past capacity")
	`ASSERT_ALWAYS(a_put_room, clk, arst_n, !(state_q == S_PUT) || !full, "insert into full list")
	`ASSERT_NEXT(a_out_load, clk, arst_n, state_q == S_OUT && !out_valid_q, out_valid_q && state_q == S_IDLE, "result not loaded")

endmodule

@@ test/indexed_list_engine_test.sv @@
`timescale 1ns / 100ps

module indexed_list_engine_test;
	import ile_pkg::*;

	localparam int unsigned DEPTH = CAPACITY_DEF;
	localparam int unsigned CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [1:0]         st;
		logic signed [31:0] rd;
		logic [5:0]         idx;
		logic [6:0]         cnt;
		logic               emp;
	} list_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [3:0]         cmd;
	logic [7:0]         position;
	logic signed [31:0] value;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         status;
	logic signed [31:0] read_value;
	logic [5:0]         found_index;
	logic [6:0]         item_count;
	logic               is_empty;

	logic signed [31:0] list_model[$];
	list_result_t       pending_results[$];
	int                 send_idle_pct;
	int                 recv_stall_pct;
	int                 hold_req;
	int                 hold_seen;
	int                 hold_left;
	int                 cycle_count;
	int                 error_count;
	int                 checked_count;
	int                 full_count;
	int                 miss_count;
	int                 peak_count;

	indexed_list_engine dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .position(position), .value(value), .out_valid(out_valid),
		.out_ready(out_ready), .status(status), .read_value(read_value),
		.found_index(found_index), .item_count(item_count), .is_empty(is_empty)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Apply one command to the list copy and return the result it should give.
	function automatic list_result_t apply_list_cmd(logic [3:0] c, logic [7:0] p,
			logic signed [31:0] v);
		list_result_t r;
		int n;
		int at;
		n = list_model.size();
		r.st = ST_MISS;
		r.rd = '0;
		r.idx = '0;
		case (c)
			CMD_ADD_FIRST, CMD_ADD_LAST, CMD_INSERT_BEFORE, CMD_INSERT_AFTER: begin
				if (n >= DEPTH) begin
					r.st = ST_FULL;
				end else begin
					if (c == CMD_ADD_FIRST) at = 0;
					else if (c == CMD_ADD_LAST) at = n;
					else if (c == CMD_INSERT_BEFORE) at = (p >= n) ? n : p;
					else at = (p >= n) ? n : p + 1;
					list_model.insert(at, v);
					r.st = ST_OK;
				end
			end
			CMD_REMOVE_FIRST, CMD_REMOVE_LAST, CMD_REMOVE_AT: begin
				if (n != 0) begin
					if (c == CMD_REMOVE_FIRST) at = 0;
					else if (c == CMD_REMOVE_LAST) at = n - 1;
					else at = p;
					if (at < n) begin
						r.rd = list_model[at];
						list_model.delete(at);
						r.st = ST_OK;
					end
				end
			end
			CMD_READ_AT: begin
				if (p < n) begin
					r.rd = list_model[p];
					r.st = ST_OK;
				end
			end
			CMD_FIND_VALUE: begin
				for (int i = 0; i < n; i++) begin
					if (list_model[i] == v) begin
						r.idx = i[5:0];
						r.st = ST_OK;
						break;
					end
				end
			end
			default: r.st = ST_MISS;
		endcase
		r.cnt = 7'(list_model.size());
		r.emp = (list_model.size() == 0);
		if (r.st == ST_FULL) full_count++;
		if (r.st == ST_MISS) miss_count++;
		if (list_model.size() > peak_count) peak_count = list_model.size();
		return r;
	endfunction

	// Offer one word; valid stays up between back-to-back words.
	task automatic send_word(logic [3:0] c, logic [7:0] p, logic signed [31:0] v);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		position <= p;
		value <= v;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(apply_list_cmd(c, p, v));
	endtask

	task automatic finish_sending();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Receiver: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= 400;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		list_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing expected: status %0d value %0d count %0d",
					$time, status, read_value, item_count);
				error_count++;
			end else begin
				e = pending_results.pop_front();
				checked_count++;
				if (status !== e.st) begin
					$display("%0t: status expected %0d actual %0d", $time, e.st, status);
					error_count++;
				end
				if (read_value !== e.rd) begin
					$display("%0t: read_value expected %0d actual %0d", $time, e.rd,
						read_value);
					error_count++;
				end
				if (found_index !== e.idx) begin
					$display("%0t: found_index expected %0d actual %0d", $time, e.idx,
						found_index);
					error_count++;
				end
				if (item_count !== e.cnt) begin
					$display("%0t: item_count expected %0d actual %0d", $time, e.cnt,
						item_count);
					error_count++;
				end
				if (is_empty !== e.emp) begin
					$display("%0t: is_empty expected %0d actual %0d", $time, e.emp, is_empty);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic signed [31:0] pick_value(logic [3:0] c);
		int n;
		n = list_model.size();
		if (c == CMD_FIND_VALUE && n != 0 && $urandom_range(1) == 0)
			return list_model[$urandom_range(n - 1)];
		case ($urandom_range(9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'($urandom_range(7));
			default: return 32'($urandom);
		endcase
	endfunction

	function automatic logic [3:0] pick_cmd(int grow_pct);
		int r;
		r = $urandom_range(99);
		if (r < grow_pct) return 4'($urandom_range(CMD_INSERT_AFTER, CMD_ADD_FIRST));
		if (r < 95) return 4'($urandom_range(CMD_FIND_VALUE, CMD_REMOVE_FIRST));
		return 4'($urandom_range(15, 9));
	endfunction

	task automatic test_directed();
		send_word(CMD_REMOVE_FIRST, 8'd0, 32'sd0);
		send_word(CMD_REMOVE_LAST, 8'd0, 32'sd0);
		send_word(CMD_REMOVE_AT, 8'd0, 32'sd0);
		send_word(CMD_READ_AT, 8'd0, 32'sd0);
		send_word(CMD_FIND_VALUE, 8'd0, 32'sd0);
		send_word(4'hf, 8'hff, 32'shffffffff);
		send_word(CMD_ADD_FIRST, 8'd0, 32'sh7fffffff);
		send_word(CMD_ADD_LAST, 8'd0, 32'sh80000000);
		send_word(CMD_INSERT_BEFORE, 8'd0, 32'sd11);
		send_word(CMD_INSERT_BEFORE, 8'hff, 32'sd22);
		send_word(CMD_INSERT_AFTER, 8'hff, 32'sd33);
		send_word(CMD_INSERT_AFTER, 8'd0, 32'sd44);
		send_word(CMD_INSERT_BEFORE, 8'd2, 32'shffffffff);
		send_word(CMD_READ_AT, 8'd0, 32'sd0);
		send_word(CMD_READ_AT, 8'hff, 32'sd0);
		send_word(CMD_FIND_VALUE, 8'd0, 32'sh80000000);
		send_word(CMD_FIND_VALUE, 8'd0, 32'sd12345);
		send_word(CMD_REMOVE_AT, 8'd3, 32'sd0);
		send_word(CMD_REMOVE_AT, 8'hff, 32'sd0);
		send_word(CMD_REMOVE_LAST, 8'd0, 32'sd0);
		send_word(CMD_REMOVE_FIRST, 8'd0, 32'sd0);
		send_word(4'd9, 8'd0, 32'sd0);
		finish_sending();
		wait_drained();
	endtask

	// Fill to capacity, push against the full list, then empty it again.
	task automatic test_full_list();
		while (list_model.size() < DEPTH)
			send_word(4'($urandom_range(CMD_INSERT_AFTER, CMD_ADD_FIRST)), 8'($urandom),
				32'($urandom));
		for (int i = 0; i < 4; i++)
			send_word(i[3:0], 8'd0, 32'($urandom));
		send_word(CMD_READ_AT, 8'(DEPTH - 1), 32'sd0);
		send_word(CMD_FIND_VALUE, 8'd0, list_model[DEPTH - 1]);
		while (list_model.size() != 0)
			send_word(4'($urandom_range(CMD_REMOVE_AT, CMD_REMOVE_FIRST)),
				8'($urandom_range(list_model.size())), 32'sd0);
		finish_sending();
		wait_drained();
	endtask

	task automatic test_random(int items, int sidle, int rstall);
		logic [3:0] c;
		logic [7:0] p;
		send_idle_pct = sidle;
		recv_stall_pct = rstall;
		for (int i = 0; i < items; i++) begin
			c = pick_cmd(((i / 80) % 2 == 0) ? 70 : 25);
			p = 8'(($urandom_range(9) == 0) ? $urandom :
				$urandom_range(list_model.size() + 1));
			send_word(c, p, pick_value(c));
		end
		finish_sending();
		wait_drained();
	endtask

	// Hold the receiver off while words keep coming so the input stalls.
	task automatic test_output_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req++;
		for (int i = 0; i < 12; i++)
			send_word(4'($urandom_range(CMD_FIND_VALUE, CMD_ADD_FIRST)),
				8'($urandom_range(4)), 32'($urandom));
		finish_sending();
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid <= 1'b0;
		cmd <= '0;
		position <= '0;
		value <= '0;
		out_ready <= 1'b0;
		hold_req = 0;
		hold_seen = 0;
		hold_left = 0;
		cycle_count = 0;
		error_count = 0;
		checked_count = 0;
		full_count = 0;
		miss_count = 0;
		peak_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_list();
		test_output_backpressure();
		test_random(280, 0, 0);
		test_random(280, 77, 0);
		test_random(280, 0, 77);
		test_random(280, 31, 31);
		test_output_backpressure();

		repeat (200) @(posedge clk);
		$display("Checked %0d results: %0d full rejects, %0d misses, peak length %0d.",
			checked_count, full_count, miss_count, peak_count);
		$display("Covered all commands, unused codes, full and empty list, output hold-off.");
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
